>>> design/byte_word_run_counter_defines.svh
// Assertion macros used by the word counter state module.
`ifndef BYTE_WORD_RUN_COUNTER_DEFINES_SVH
`define BYTE_WORD_RUN_COUNTER_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define BWRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define BWRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bwrc_pkg.sv
// Types, constants and the byte classifier for the word counter.
package bwrc_pkg;

  localparam int unsigned WORD_TOTAL_W = 32;
  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [BYTE_W-1:0] WS_LOW = 8'h09;
  localparam logic [BYTE_W-1:0] WS_HIGH = 8'h0D;
  localparam logic [BYTE_W-1:0] PRINT_LOW = 8'h21;
  localparam logic [BYTE_W-1:0] PRINT_HIGH = 8'h7E;

  typedef enum logic [1:0] {
    CLS_SEP,
    CLS_PRINT,
    CLS_OTHER
  } byte_class_e;

  typedef struct packed {
    logic        valid;
    byte_class_e cls;
  } class_item_t;

  function automatic byte_class_e classify(input logic [BYTE_W-1:0] b);
    byte_class_e cls;
    if (b == SPACE_CHAR || (b >= WS_LOW && b <= WS_HIGH)) begin
      cls = CLS_SEP;
    end else if (b >= PRINT_LOW && b <= PRINT_HIGH) begin
      cls = CLS_PRINT;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

>>> design/bwrc_in_stage.sv
// Input register that holds the class of the accepted byte.
module bwrc_in_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      take_i,
  output bwrc_pkg::class_item_t     item_o
);
  import bwrc_pkg::*;

  logic        valid_q;
  byte_class_e cls_q;
  logic        load;

  assign in_ready_o = rst_ni && (!valid_q || take_i);
  assign load = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cls_q <= classify(data_byte_i);
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.cls = cls_q;

endmodule

>>> design/bwrc_state.sv
// Run tracking state, word counter and result register.
`include "byte_word_run_counter_defines.svh"

module bwrc_state #(
  parameter int unsigned CountBits = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bwrc_pkg::class_item_t  item_i,
  output logic                   take_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [31:0]            word_total_o,
  output logic                   any_byte_seen_o,
  output logic                   began_in_run_o,
  output logic                   separator_seen_o,
  output logic                   open_run_o,
  output logic                   open_run_printable_o,
  output logic                   lead_closed_o,
  output logic                   lead_printable_o
);
  import bwrc_pkg::*;

  logic                 out_valid_q;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic any_q, any_d;
  logic began_q, began_d;
  logic sep_seen_q, sep_seen_d;
  logic run_q, run_d;
  logic run_pr_q, run_pr_d;
  logic lead_cl_q, lead_cl_d;
  logic lead_pr_q, lead_pr_d;
  logic is_sep;

  assign take_o = item_i.valid && (!out_valid_q || out_ready_i);
  assign is_sep = (item_i.cls == CLS_SEP);

  always_comb begin
    any_d = 1'b1;
    began_d = any_q ? began_q : !is_sep;
    sep_seen_d = sep_seen_q;
    run_d = run_q;
    run_pr_d = run_pr_q;
    cnt_d = cnt_q;
    lead_cl_d = lead_cl_q;
    lead_pr_d = lead_pr_q;
    if (is_sep) begin
      if (run_q) begin
        if (run_pr_q && cnt_q != {CountBits{1'b1}}) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (!sep_seen_q && began_d) begin
          lead_cl_d = 1'b1;
          lead_pr_d = run_pr_q;
        end
        run_d = 1'b0;
        run_pr_d = 1'b0;
      end
      sep_seen_d = 1'b1;
    end else begin
      run_d = 1'b1;
      if (item_i.cls == CLS_PRINT) begin
        run_pr_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q <= '0;
      any_q <= 1'b0;
      began_q <= 1'b0;
      sep_seen_q <= 1'b0;
      run_q <= 1'b0;
      run_pr_q <= 1'b0;
      lead_cl_q <= 1'b0;
      lead_pr_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= item_i.valid;
      end
      if (take_o) begin
        cnt_q <= cnt_d;
        any_q <= any_d;
        began_q <= began_d;
        sep_seen_q <= sep_seen_d;
        run_q <= run_d;
        run_pr_q <= run_pr_d;
        lead_cl_q <= lead_cl_d;
        lead_pr_q <= lead_pr_d;
      end
    end
  end

  if (CountBits >= WORD_TOTAL_W) begin : g_wide
    assign word_total_o = cnt_q[WORD_TOTAL_W-1:0];
  end else begin : g_narrow
    assign word_total_o = {{(WORD_TOTAL_W - CountBits){1'b0}}, cnt_q};
  end

  assign out_valid_o = out_valid_q;
  assign any_byte_seen_o = any_q;
  assign began_in_run_o = began_q;
  assign separator_seen_o = sep_seen_q;
  assign open_run_o = run_q;
  assign open_run_printable_o = run_pr_q;
  assign lead_closed_o = lead_cl_q;
  assign lead_printable_o = lead_pr_q;

  `BWRC_ASSERT_NEXT(a_cnt_step, take_o, cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + 1'b1, "word counter moved by more than one")
  `BWRC_ASSERT_NEXT(a_hold_on_stall, !take_o, $stable(cnt_q) && $stable(run_q) && $stable(any_q), "state changed without a new item")
  `BWRC_ASSERT(a_lead_needs_sep, !lead_cl_q || (sep_seen_q && began_q), "leading run closed without a separator")
  `BWRC_ASSERT(a_pr_needs_run, !run_pr_q || run_q, "printable flag set outside a run")
  `BWRC_ASSERT(a_lead_pr, !lead_pr_q || lead_cl_q, "leading run printable but not closed")

endmodule

>>> design/byte_word_run_counter.sv
// Top level of the byte stream word counter.
//
//   Channel  Handshake               Payload
//   input    in_valid_i/in_ready_o   data_byte_i
//   output   out_valid_o/out_ready_i word_total_o and seven status flags
//
// One item accepted per cycle unless the output stalls; it passes input and result registers.
// The classifier sits in front of the input register; the path from there to the result
// register is the run update and one counter increment with a saturation compare.
// Reset clears all flags and the counter; no item is accepted while reset is held.
// A stalled output holds the state; the input register keeps taking an item as it drains.
module byte_word_run_counter #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] word_total_o,
  output logic        any_byte_seen_o,
  output logic        began_in_run_o,
  output logic        separator_seen_o,
  output logic        open_run_o,
  output logic        open_run_printable_o,
  output logic        lead_closed_o,
  output logic        lead_printable_o
);
  import bwrc_pkg::*;

  class_item_t item;
  logic        take;

  bwrc_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .take_i      (take),
    .item_o      (item)
  );

  bwrc_state #(
    .CountBits (COUNT_BITS)
  ) u_state (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .item_i               (item),
    .take_o               (take),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .word_total_o         (word_total_o),
    .any_byte_seen_o      (any_byte_seen_o),
    .began_in_run_o       (began_in_run_o),
    .separator_seen_o     (separator_seen_o),
    .open_run_o           (open_run_o),
    .open_run_printable_o (open_run_printable_o),
    .lead_closed_o        (lead_closed_o),
    .lead_printable_o     (lead_printable_o)
  );

endmodule

>>> bench/byte_word_run_counter_tb.sv
// Self-checking testbench for the byte stream word counter, with random handshake stalls.
`timescale 1ns / 100ps

module byte_word_run_counter_tb;
  import bwrc_pkg::*;

  localparam int unsigned COUNT_W = 32;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam logic [7:0] EDGE_BYTES [16] = '{
    8'h0B, 8'h0C, 8'h21, 8'h7E, 8'h20, 8'h08, 8'h0E, 8'h1F,
    8'h09, 8'h7F, 8'h41, 8'h0A, 8'hFF, 8'h80, 8'h00, 8'h0D
  };
  localparam logic [7:0] SEP_BYTES [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  typedef struct packed {
    logic [31:0] word_total;
    logic        any_byte;
    logic        began;
    logic        sep_seen;
    logic        in_run;
    logic        run_printable;
    logic        lead_closed;
    logic        lead_printable;
  } tally_t;

  class run_tally_board;
    logic        any_byte;
    logic        began;
    logic        sep_seen;
    logic        in_run;
    logic        run_printable;
    logic        lead_closed;
    logic        lead_printable;
    logic [63:0] words;
    logic [63:0] word_limit;
    tally_t      expected_tallies[$];
    int unsigned mismatches;

    function new(int unsigned count_w);
      word_limit = (count_w >= 64) ? '1 : (64'd1 << count_w) - 64'd1;
      any_byte = 1'b0;
      began = 1'b0;
      sep_seen = 1'b0;
      in_run = 1'b0;
      run_printable = 1'b0;
      lead_closed = 1'b0;
      lead_printable = 1'b0;
      words = '0;
      mismatches = 0;
    endfunction

    function byte_class_e class_of(logic [7:0] b);
      if (b == SPACE_CHAR || (b >= WS_LOW && b <= WS_HIGH)) begin
        return CLS_SEP;
      end
      if (b >= PRINT_LOW && b <= PRINT_HIGH) begin
        return CLS_PRINT;
      end
      return CLS_OTHER;
    endfunction

    function void note_byte(logic [7:0] b);
      byte_class_e cls;
      tally_t t;
      cls = class_of(b);
      if (!any_byte) begin
        any_byte = 1'b1;
        began = (cls != CLS_SEP);
      end
      if (cls == CLS_SEP) begin
        if (in_run) begin
          if (run_printable && words < word_limit) begin
            words = words + 64'd1;
          end
          if (!sep_seen && began) begin
            lead_closed = 1'b1;
            lead_printable = run_printable;
          end
          in_run = 1'b0;
          run_printable = 1'b0;
        end
        sep_seen = 1'b1;
      end else begin
        in_run = 1'b1;
        if (cls == CLS_PRINT) begin
          run_printable = 1'b1;
        end
      end
      t.word_total = words[31:0];
      t.any_byte = any_byte;
      t.began = began;
      t.sep_seen = sep_seen;
      t.in_run = in_run;
      t.run_printable = run_printable;
      t.lead_closed = lead_closed;
      t.lead_printable = lead_printable;
      expected_tallies.push_back(t);
    endfunction

    function void compare(string what, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $display("%0t: %s expected %0h, got %0h", $time, what, exp, act);
        mismatches++;
      end
    endfunction

    function void compare_flag(string what, logic exp, logic act);
      if (exp !== act) begin
        $display("%0t: %s expected %0b, got %0b", $time, what, exp, act);
        mismatches++;
      end
    endfunction

    function void check_tally(tally_t got);
      tally_t exp;
      if (expected_tallies.size() == 0) begin
        $display("%0t: result with none expected, got total %0h", $time, got.word_total);
        mismatches++;
        return;
      end
      exp = expected_tallies.pop_front();
      compare("word_total", exp.word_total, got.word_total);
      compare_flag("any_byte_seen", exp.any_byte, got.any_byte);
      compare_flag("began_in_run", exp.began, got.began);
      compare_flag("separator_seen", exp.sep_seen, got.sep_seen);
      compare_flag("open_run", exp.in_run, got.in_run);
      compare_flag("open_run_printable", exp.run_printable, got.run_printable);
      compare_flag("lead_closed", exp.lead_closed, got.lead_closed);
      compare_flag("lead_printable", exp.lead_printable, got.lead_printable);
    endfunction

    function int unsigned pending();
      return expected_tallies.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] word_total_o;
  logic        any_byte_seen_o;
  logic        began_in_run_o;
  logic        separator_seen_o;
  logic        open_run_o;
  logic        open_run_printable_o;
  logic        lead_closed_o;
  logic        lead_printable_o;

  run_tally_board board;
  int unsigned    burst_left;
  int unsigned    items_sent;
  logic [15:0]    ready_pattern = 16'hFFFF;
  int unsigned    pattern_left = 0;

  byte_word_run_counter #(
    .COUNT_BITS(COUNT_W)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .data_byte_i         (data_byte_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .word_total_o        (word_total_o),
    .any_byte_seen_o     (any_byte_seen_o),
    .began_in_run_o      (began_in_run_o),
    .separator_seen_o    (separator_seen_o),
    .open_run_o          (open_run_o),
    .open_run_printable_o(open_run_printable_o),
    .lead_closed_o       (lead_closed_o),
    .lead_printable_o    (lead_printable_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(negedge clk_i) begin
    if (pattern_left == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern = 16'hFFFF;
        1: ready_pattern = 16'($urandom);
        2: ready_pattern = 16'($urandom & $urandom);
        default: ready_pattern = 16'($urandom | $urandom);
      endcase
      pattern_left = $urandom_range(16, 64);
    end else begin
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      pattern_left--;
    end
    out_ready_i <= ready_pattern[0];
  end

  always @(posedge clk_i) begin
    tally_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        board.note_byte(data_byte_i);
      end
      if (out_valid_o && out_ready_i) begin
        got.word_total = word_total_o;
        got.any_byte = any_byte_seen_o;
        got.began = began_in_run_o;
        got.sep_seen = separator_seen_o;
        got.in_run = open_run_o;
        got.run_printable = open_run_printable_o;
        got.lead_closed = lead_closed_o;
        got.lead_printable = lead_printable_o;
        board.check_tally(got);
      end
    end
  end

  function automatic logic [7:0] pick_other();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(0, 8));
      1: return 8'($urandom_range(14, 31));
      default: return 8'($urandom_range(127, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_sep();
    return SEP_BYTES[$urandom_range(0, 5)];
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic push_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  initial begin
    int unsigned kind;
    int unsigned len;
    board = new(COUNT_W);
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = 8'h00;
    burst_left = 0;
    items_sent = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The stream can be entered only once, so the seed picks how it starts.
    case ($urandom_range(0, 2))
      0: begin
        push_byte(8'h20);
        push_byte(8'h09);
      end
      1: begin
        push_byte(8'h41);
        push_byte(8'h80);
        push_byte(8'h0A);
      end
      default: begin
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h7F);
        push_byte(8'h0D);
      end
    endcase
    for (int i = 0; i < 16; i++) begin
      push_byte(EDGE_BYTES[i]);
    end

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 2);
        for (int i = 0; i < len; i++) begin
          push_byte(($urandom_range(0, 5) == 0) ? pick_other() : 8'($urandom_range(33, 126)));
        end
        repeat ($urandom_range(1, 2)) push_byte(pick_sep());
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) push_byte(pick_other());
        push_byte(pick_sep());
      end
    end
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> byte_word_run_counter.f
+incdir+design
design/bwrc_pkg.sv
design/bwrc_in_stage.sv
design/bwrc_state.sv
design/byte_word_run_counter.sv
bench/byte_word_run_counter_tb.sv
